### hdl/hsfc_pkg.sv
`default_nettype none
package hsfc_pkg;
	localparam logic FUNC_S2H = 1'b0;
	localparam logic FUNC_H2S = 1'b1;

	localparam logic [31:0] SGN32      = 32'h8000_0000;
	localparam logic [31:0] KEEP_MASK  = 32'hffff_f000;
	localparam logic [31:0] EXP32_ALL  = 32'h7f80_0000;
	localparam logic [31:0] HALF_INF32 = 32'h0f80_0000;
	localparam logic [7:0]  BIAS_DIFF  = 8'd112;

	typedef struct packed {
		logic        func;
		logic [31:0] operand;
		logic        batch_end;
	} item_t;

	typedef struct packed {
		logic [31:0] converted;
		logic        batch_end_out;
	} result_t;
endpackage
`default_nettype wire

### hdl/half_single_float_converter_top.sv
`default_nettype none
// channel | dir | tdata                          | tlast
// s_axis  | in  | [31:0] operand                 | batch_end
// s_axis  | in  | tuser[0] func                  |
// m_axis  | out | [31:0] converted              | batch_end_out
// One transaction per cycle unless the output stalls; input register then result register.
// Reset empties both registers. A stall holds the result; the input register
// advances while it is empty or the result register is free or being drained.
module half_single_float_converter_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,  // operand
	input  wire         s_axis_tuser,  // func
	input  wire         s_axis_tlast,  // batch_end
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,  // converted
	output logic        m_axis_tlast   // batch_end_out
);
	import hsfc_pkg::*;

	item_t   in_s1;
	logic    vld_s1;
	result_t comb_res, out_s2;
	logic    adv;

	hsfc_core u_core (.item(in_s1), .res(comb_res));

	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv || !vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tready)
				vld_s1 <= s_axis_tvalid;
			if (adv)
				m_axis_tvalid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready)
			in_s1 <= '{func: s_axis_tuser, operand: s_axis_tdata, batch_end: s_axis_tlast};
		if (adv && vld_s1)
			out_s2 <= comb_res;
	end

	assign m_axis_tdata = out_s2.converted;
	assign m_axis_tlast = out_s2.batch_end_out;
endmodule
`default_nettype wire

### hdl/hsfc_core.sv
`default_nettype none
module hsfc_core (
	input  hsfc_pkg::item_t   item,
	output hsfc_pkg::result_t res
);
	import hsfc_pkg::*;

	logic [31:0] sgn, a, ak, r, mant, q, rem, halfv, mask, h2s;
	logic [7:0]  e;
	logic [6:0]  s;
	logic [15:0] s2h;
	logic [15:0] h;
	logic [4:0]  he;
	logic [9:0]  hm, nm;
	logic [3:0]  lz;
	logic [7:0]  be;

	always_comb begin
		sgn = item.operand & SGN32;
		a = item.operand ^ sgn;
		ak = a & KEEP_MASK;
		e = ak[30:23];
		mant = {8'd0, 1'b1, ak[22:0]};
		s = 7'd113 - e[6:0];
		mask = (32'd1 << s[4:0]) - 32'd1;
		q = mant >> s[4:0];
		rem = mant & mask;
		halfv = 32'd1 << (s[4:0] - 5'd1);
		if (e > BIAS_DIFF) begin
			r = ak - {1'b0, BIAS_DIFF, 23'd0};
		end else if (e == 8'd0 || s > 7'd25) begin
			r = 32'd0;
		end else if (rem > halfv || (rem == halfv && q[0])) begin
			r = q + 32'd1;
		end else begin
			r = q;
		end
		r = r + 32'h1000;
		if (r > HALF_INF32)
			r = HALF_INF32;
		if (a > EXP32_ALL)
			s2h = 16'h7e00;
		else if (a == EXP32_ALL)
			s2h = 16'h7c00;
		else
			s2h = r[28:13];
		s2h = s2h | sgn[31:16];

		h = item.operand[15:0];
		he = h[14:10];
		hm = h[9:0];
		lz = 4'd0;
		for (int i = 9; i >= 0; i--) begin
			if (hm[i] && lz == 4'd0)
				lz = 4'(10 - i);
		end
		nm = hm << lz;
		be = 8'd113 - {4'd0, lz};
		if (he == 5'd31)
			h2s = EXP32_ALL | {9'd0, hm, 13'd0};
		else if (he != 5'd0)
			h2s = {1'b0, 3'd0, he, 23'd0} + {1'b0, BIAS_DIFF, 23'd0} | {9'd0, hm, 13'd0};
		else if (hm == 10'd0)
			h2s = 32'd0;
		else
			h2s = {1'b0, be, nm, 13'd0};
		h2s[31] = h[15];

		res.converted = (item.func == FUNC_H2S) ? h2s : {16'd0, s2h};
		res.batch_end_out = item.batch_end;
	end
endmodule
`default_nettype wire
